>>> sv/path_position_index_unit_defines.svh
// Assertion macros used by the checker file of the path position index.
`ifndef PATH_POSITION_INDEX_UNIT_DEFINES_SVH
`define PATH_POSITION_INDEX_UNIT_DEFINES_SVH

// Property checked on every rising edge outside reset.
`define PPI_ASSERT(label, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("path position index check failed");

// Property checked on every rising edge, reset included.
`define PPI_ASSERT_ALWAYS(label, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("path position index reset check failed");

`endif

>>> sv/ppi_pkg.sv
`default_nettype none

package ppi_pkg;

  // Sizing of the index.
  localparam int MAX_STEPS = 4096;
  localparam int MAX_PATHS = 256;
  localparam int POS_W     = 48;

  // Fixed field widths of the stream items.
  localparam int PATH_ID_W = 8;
  localparam int WORD_W    = 64;
  localparam int LEN_W     = 32;

  localparam int SLOT_W     = $clog2(MAX_STEPS);
  localparam int CURSOR_W   = $clog2(MAX_STEPS + 1);
  localparam int PATH_IDX_W = (MAX_PATHS > 1) ? $clog2(MAX_PATHS) : 1;

  localparam logic [PATH_ID_W:0]  PATHS_LIMIT = (PATH_ID_W + 1)'(MAX_PATHS);
  localparam logic [CURSOR_W-1:0] STEPS_LIMIT = CURSOR_W'(MAX_STEPS);
  localparam logic [POS_W-1:0]    POS_MAX     = {POS_W{1'b1}};

  // Input tdata layout, lowest bit first.
  localparam int IN_PATH_LSB = 0;
  localparam int IN_HI_LSB   = IN_PATH_LSB + PATH_ID_W;
  localparam int IN_LO_LSB   = IN_HI_LSB + WORD_W;
  localparam int IN_LEN_LSB  = IN_LO_LSB + WORD_W;
  localparam int IN_POS_LSB  = IN_LEN_LSB + LEN_W;
  localparam int IN_USED_W   = IN_POS_LSB + POS_W;
  localparam int IN_DATA_W   = ((IN_USED_W + 7) / 8) * 8;

  // Output tdata layout, lowest bit first.
  localparam int OUT_HI_LSB  = 0;
  localparam int OUT_LO_LSB  = OUT_HI_LSB + WORD_W;
  localparam int OUT_LEN_LSB = OUT_LO_LSB + WORD_W;
  localparam int OUT_USED_W  = OUT_LEN_LSB + POS_W;
  localparam int OUT_DATA_W  = ((OUT_USED_W + 7) / 8) * 8;

  // tuser bit positions.
  localparam int USER_W          = 2;
  localparam int IN_USER_OP      = 0;
  localparam int IN_USER_FIRST   = 1;
  localparam int OUT_USER_PAST   = 0;
  localparam int OUT_USER_UNKNWN = 1;

  typedef enum logic [1:0] {
    EMIT_NONE,
    EMIT_UNKNOWN,
    EMIT_PAST,
    EMIT_FOUND
  } emit_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic  load;
    logic  append;
    logic  range_rd;
    logic  search_init;
    logic  search_step;
    emit_t emit;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic in_query;
    logic known;
    logic no_cover;
    logic wide;
    logic more;
    logic out_free;
  } sts_t;

  function automatic logic [CURSOR_W-1:0] mid_of(input logic [CURSOR_W-1:0] lo,
                                                 input logic [CURSOR_W-1:0] hi);
    logic [CURSOR_W-1:0] span;
    span = hi - lo;
    return lo + (span >> 1);
  endfunction

endpackage

`default_nettype wire

>>> sv/ppi_ctrl.sv
`default_nettype none

module ppi_ctrl (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          in_valid,
  output logic               in_ready,
  input  wire ppi_pkg::sts_t sts,
  output ppi_pkg::cmd_t      cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_APPEND,
    S_RANGE,
    S_CHECK,
    S_BISECT,
    S_FINISH
  } state_t;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next      = state;
    cmd             = '0;
    cmd.emit        = ppi_pkg::EMIT_NONE;
    in_ready        = 1'b0;
    unique case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = sts.in_query ? S_RANGE : S_APPEND;
        end
      end
      S_APPEND: begin
        cmd.append = 1'b1;
        state_next = S_IDLE;
      end
      S_RANGE: begin
        cmd.range_rd = 1'b1;
        state_next   = S_CHECK;
      end
      S_CHECK: begin
        if (!sts.known) begin
          if (sts.out_free) begin
            cmd.emit   = ppi_pkg::EMIT_UNKNOWN;
            state_next = S_IDLE;
          end
        end else if (sts.no_cover) begin
          if (sts.out_free) begin
            cmd.emit   = ppi_pkg::EMIT_PAST;
            state_next = S_IDLE;
          end
        end else begin
          cmd.search_init = 1'b1;
          state_next      = sts.wide ? S_BISECT : S_FINISH;
        end
      end
      S_BISECT: begin
        cmd.search_step = 1'b1;
        state_next      = sts.more ? S_BISECT : S_FINISH;
      end
      S_FINISH: begin
        if (sts.out_free) begin
          cmd.emit   = ppi_pkg::EMIT_FOUND;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

>>> sv/ppi_dp.sv
`default_nettype none

module ppi_dp (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic [ppi_pkg::IN_DATA_W-1:0]      in_data,
  input  wire logic [ppi_pkg::USER_W-1:0]         in_user,
  output logic                                    out_valid,
  input  wire logic                               out_ready,
  output logic [ppi_pkg::OUT_DATA_W-1:0]          out_data,
  output logic [ppi_pkg::USER_W-1:0]              out_user,
  input  wire ppi_pkg::cmd_t                      cmd,
  output ppi_pkg::sts_t                           sts
);

  // Latched input item.
  logic [ppi_pkg::PATH_ID_W-1:0] path;
  logic                          first;
  logic [ppi_pkg::WORD_W-1:0]    step_hi;
  logic [ppi_pkg::WORD_W-1:0]    step_lo;
  logic [ppi_pkg::LEN_W-1:0]     node_len;
  logic [ppi_pkg::POS_W-1:0]     pos;

  // Index control state.
  logic [ppi_pkg::CURSOR_W-1:0]  cursor;
  logic [ppi_pkg::POS_W-1:0]     running;
  logic [ppi_pkg::MAX_PATHS-1:0] present;

  // Memories.
  logic [ppi_pkg::WORD_W-1:0]   hi_mem    [ppi_pkg::MAX_STEPS];
  logic [ppi_pkg::WORD_W-1:0]   lo_mem    [ppi_pkg::MAX_STEPS];
  logic [ppi_pkg::POS_W-1:0]    start_mem [ppi_pkg::MAX_STEPS];
  logic [ppi_pkg::CURSOR_W-1:0] first_mem [ppi_pkg::MAX_PATHS];
  logic [ppi_pkg::CURSOR_W-1:0] after_mem [ppi_pkg::MAX_PATHS];
  logic [ppi_pkg::POS_W-1:0]    total_mem [ppi_pkg::MAX_PATHS];

  // Registered read data.
  logic [ppi_pkg::WORD_W-1:0]   hi_rd;
  logic [ppi_pkg::WORD_W-1:0]   lo_rd;
  logic [ppi_pkg::POS_W-1:0]    start_rd;
  logic [ppi_pkg::CURSOR_W-1:0] first_rd;
  logic [ppi_pkg::CURSOR_W-1:0] after_rd;
  logic [ppi_pkg::POS_W-1:0]    total_rd;

  // Bisection bounds and the slot whose data is in the read registers.
  logic [ppi_pkg::CURSOR_W-1:0] lo;
  logic [ppi_pkg::CURSOR_W-1:0] hi;
  logic [ppi_pkg::CURSOR_W-1:0] mid;

  logic [ppi_pkg::PATH_IDX_W-1:0] idx;
  logic                           path_ok;
  logic                           room;
  logic                           do_write;
  logic                           opening;
  logic [ppi_pkg::POS_W-1:0]      start_pos;
  logic [ppi_pkg::POS_W:0]        sum;
  logic [ppi_pkg::POS_W-1:0]      running_next;
  logic [ppi_pkg::CURSOR_W-1:0]   cursor_next;
  logic [ppi_pkg::CURSOR_W-1:0]   hi_clamp;
  logic                           lt;
  logic [ppi_pkg::CURSOR_W-1:0]   lo_next;
  logic [ppi_pkg::CURSOR_W-1:0]   hi_next;
  logic [ppi_pkg::CURSOR_W-1:0]   rd_addr;
  logic                           step_rd;
  logic                           wide;
  logic                           more;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      path     <= in_data[ppi_pkg::IN_PATH_LSB +: ppi_pkg::PATH_ID_W];
      first    <= in_user[ppi_pkg::IN_USER_FIRST];
      step_hi  <= in_data[ppi_pkg::IN_HI_LSB +: ppi_pkg::WORD_W];
      step_lo  <= in_data[ppi_pkg::IN_LO_LSB +: ppi_pkg::WORD_W];
      node_len <= in_data[ppi_pkg::IN_LEN_LSB +: ppi_pkg::LEN_W];
      pos      <= in_data[ppi_pkg::IN_POS_LSB +: ppi_pkg::POS_W];
    end
  end

  always_comb begin
    idx          = path[ppi_pkg::PATH_IDX_W-1:0];
    path_ok      = {1'b0, path} < ppi_pkg::PATHS_LIMIT;
    room         = cursor < ppi_pkg::STEPS_LIMIT;
    do_write     = cmd.append && path_ok && room;
    opening      = first || !present[idx];
    start_pos    = opening ? '0 : running;
    sum          = {1'b0, start_pos} + (ppi_pkg::POS_W + 1)'(node_len);
    running_next = (sum >= {1'b0, ppi_pkg::POS_MAX}) ? ppi_pkg::POS_MAX
                                                      : sum[ppi_pkg::POS_W-1:0];
    cursor_next  = cursor + 1'b1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cursor  <= '0;
      running <= '0;
      present <= '0;
    end else if (do_write) begin
      cursor       <= cursor_next;
      running      <= running_next;
      present[idx] <= 1'b1;
    end
  end

  // Search arithmetic.
  always_comb begin
    hi_clamp = (after_rd > ppi_pkg::STEPS_LIMIT) ? ppi_pkg::STEPS_LIMIT : after_rd;
    wide     = {1'b0, hi_clamp} > ({1'b0, first_rd} + 1'b1);
    lt       = pos < start_rd;
    lo_next  = lt ? lo : mid;
    hi_next  = lt ? mid : hi;
    more     = {1'b0, hi_next} > ({1'b0, lo_next} + 1'b1);
    if (cmd.search_init) begin
      rd_addr = wide ? ppi_pkg::mid_of(first_rd, hi_clamp) : first_rd;
    end else begin
      rd_addr = more ? ppi_pkg::mid_of(lo_next, hi_next) : lo_next;
    end
    step_rd = cmd.search_init || cmd.search_step;
  end

  always_ff @(posedge clk) begin
    if (cmd.search_init) begin
      lo  <= first_rd;
      hi  <= hi_clamp;
      mid <= rd_addr;
    end else if (cmd.search_step) begin
      lo  <= lo_next;
      hi  <= hi_next;
      mid <= rd_addr;
    end
  end

  // Step memories: one write port, one registered read port.
  always_ff @(posedge clk) begin
    if (do_write) begin
      hi_mem[cursor[ppi_pkg::SLOT_W-1:0]]    <= step_hi;
      lo_mem[cursor[ppi_pkg::SLOT_W-1:0]]    <= step_lo;
      start_mem[cursor[ppi_pkg::SLOT_W-1:0]] <= start_pos;
    end
    if (step_rd) begin
      hi_rd    <= hi_mem[rd_addr[ppi_pkg::SLOT_W-1:0]];
      lo_rd    <= lo_mem[rd_addr[ppi_pkg::SLOT_W-1:0]];
      start_rd <= start_mem[rd_addr[ppi_pkg::SLOT_W-1:0]];
    end
  end

  // Per-path memories.
  always_ff @(posedge clk) begin
    if (do_write) begin
      if (opening) begin
        first_mem[idx] <= cursor;
      end
      after_mem[idx] <= cursor_next;
      total_mem[idx] <= running_next;
    end
    if (cmd.range_rd) begin
      first_rd <= first_mem[idx];
      after_rd <= after_mem[idx];
      total_rd <= total_mem[idx];
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit != ppi_pkg::EMIT_NONE) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    unique case (cmd.emit)
      ppi_pkg::EMIT_UNKNOWN: begin
        out_data <= '0;
        out_user <= '0;
        out_user[ppi_pkg::OUT_USER_PAST]   <= 1'b1;
        out_user[ppi_pkg::OUT_USER_UNKNWN] <= 1'b1;
      end
      ppi_pkg::EMIT_PAST: begin
        out_data <= '0;
        out_data[ppi_pkg::OUT_LEN_LSB +: ppi_pkg::POS_W] <= total_rd;
        out_user <= '0;
        out_user[ppi_pkg::OUT_USER_PAST] <= 1'b1;
      end
      ppi_pkg::EMIT_FOUND: begin
        out_data <= '0;
        out_data[ppi_pkg::OUT_HI_LSB +: ppi_pkg::WORD_W]  <= hi_rd;
        out_data[ppi_pkg::OUT_LO_LSB +: ppi_pkg::WORD_W]  <= lo_rd;
        out_data[ppi_pkg::OUT_LEN_LSB +: ppi_pkg::POS_W] <= total_rd;
        out_user <= '0;
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    sts.in_query = in_user[ppi_pkg::IN_USER_OP];
    sts.known    = path_ok && present[idx];
    sts.no_cover = (first_rd >= hi_clamp) || (pos >= total_rd);
    sts.wide     = wide;
    sts.more     = more;
    sts.out_free = !out_valid || out_ready;
  end

endmodule

`default_nettype wire

>>> sv/path_position_index_unit.sv
// Append: written in the cycle after it is accepted; the unit is then ready again.
// Query: the path's slot range and total are read and checked, then the range is bisected,
// one bisection step per cycle on the step memories' read port.
// One item is in work at a time; a finished result waits in the output register.
// Reset (rst, synchronous, active high) clears the slot cursor, the running position, the
// path-present bits, the controller and the output valid; no memory clearing pass is needed.
`default_nettype none

module path_position_index_unit (
  input  wire logic                          clk,
  input  wire logic                          rst,
  // Input stream.
  input  wire logic                          s_tvalid,
  output logic                               s_tready,
  // tdata, lowest bit up: path_id[8], step_hi[64], step_lo[64], node_length[32],
  // query_position[48].
  input  wire logic [ppi_pkg::IN_DATA_W-1:0] s_tdata,
  // tuser, lowest bit up: operation[1], first_in_path[1].
  input  wire logic [ppi_pkg::USER_W-1:0]    s_tuser,
  // Result stream.
  output logic                               m_tvalid,
  input  wire logic                          m_tready,
  // tdata, lowest bit up: found_step_hi[64], found_step_lo[64], path_length[48].
  output logic [ppi_pkg::OUT_DATA_W-1:0]     m_tdata,
  // tuser, lowest bit up: past_end[1], unknown_path[1].
  output logic [ppi_pkg::USER_W-1:0]         m_tuser
);

  // The controller sequences each beat: an append is written in the S_APPEND state; a query
  // reads the path's slot range and total, decides between the unknown-path answer, the
  // end marker and a search, then bisects the start positions of the range. Each bisection
  // cycle compares the query position with the start position just read and forms the
  // next read address from the outcome, so the read port never idles during the search.
  // The slot that the search settles on is read with its step words in the last step.

  ppi_pkg::cmd_t cmd;
  ppi_pkg::sts_t sts;

  ppi_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  ppi_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .in_data   (s_tdata),
    .in_user   (s_tuser),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_data  (m_tdata),
    .out_user  (m_tuser),
    .cmd       (cmd),
    .sts       (sts)
  );

endmodule

`default_nettype wire

>>> sv/ppi_checker.sv
`default_nettype none
`include "path_position_index_unit_defines.svh"

module ppi_checker (
  input wire logic                          clk,
  input wire logic                          rst,
  input wire logic                          s_tvalid,
  input wire logic                          s_tready,
  input wire logic [ppi_pkg::IN_DATA_W-1:0] s_tdata,
  input wire logic [ppi_pkg::USER_W-1:0]    s_tuser,
  input wire logic                          m_tvalid,
  input wire logic                          m_tready,
  input wire logic [ppi_pkg::OUT_DATA_W-1:0] m_tdata,
  input wire logic [ppi_pkg::USER_W-1:0]    m_tuser
);

  logic in_beat;
  logic unknown_beat;
  logic past_beat;

  assign in_beat      = s_tvalid && s_tready;
  assign unknown_beat = m_tvalid && m_tuser[ppi_pkg::OUT_USER_UNKNWN];
  assign past_beat    = m_tvalid && m_tuser[ppi_pkg::OUT_USER_PAST];

  // No result survives a reset.
  `PPI_ASSERT_ALWAYS(a_reset_clears_out, rst |=> !m_tvalid)
  // Every accepted beat leaves the unit busy before it can take another beat.
  `PPI_ASSERT(a_busy_after_beat, in_beat |=> !s_tready)
  // An unknown path is also an end marker with an all-zero payload.
  `PPI_ASSERT(a_unknown_is_empty, unknown_beat |-> (past_beat && (m_tdata == '0)))
  // A held result keeps its payload.
  `PPI_ASSERT(a_out_hold, (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))

endmodule

bind path_position_index_unit ppi_checker u_ppi_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .s_tdata  (s_tdata),
  .s_tuser  (s_tuser),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser)
);

`default_nettype wire

>>> test/path_position_index_unit_test.sv
`timescale 1ns / 1ps

module path_position_index_unit_test;
  import ppi_pkg::*;

  // Cycles in which the receiver refuses results once, to back the unit up.
  localparam int HOLD_CYCLES  = 400;
  // Cycles without any accepted beat before the run is declared hung.
  localparam int STALL_LIMIT  = 4000;
  // Settling time after the last result.
  localparam int DRAIN_CYCLES = 40;

  typedef enum logic {
    OP_APPEND = 1'b0,
    OP_QUERY  = 1'b1
  } op_e;

  // One input beat in field form.
  typedef struct packed {
    op_e                  op;
    logic [PATH_ID_W-1:0] path;
    logic                 opens;
    logic [WORD_W-1:0]    hi;
    logic [WORD_W-1:0]    lo;
    logic [LEN_W-1:0]     len;
    logic [POS_W-1:0]     pos;
  } index_item_t;

  // One result beat in field form.
  typedef struct packed {
    logic [WORD_W-1:0] hi;
    logic [WORD_W-1:0] lo;
    logic [POS_W-1:0]  total;
    logic              past;
    logic              unknown;
  } lookup_result_t;

  // Keeps its own copy of the position index, works out the answer to every
  // accepted query and holds those answers until the unit delivers them.
  class position_lookup_board;
    logic [WORD_W-1:0] first_word [MAX_STEPS];
    logic [WORD_W-1:0] second_word [MAX_STEPS];
    logic [POS_W-1:0]  start_pos [MAX_STEPS];
    int unsigned       range_lo [MAX_PATHS];
    int unsigned       range_end [MAX_PATHS];
    logic [POS_W-1:0]  total_len [MAX_PATHS];
    bit                present [MAX_PATHS];
    int unsigned       cursor;
    logic [POS_W-1:0]  running;
    lookup_result_t    awaited_lookups[$];
    int                errors;

    function new();
      cursor  = 0;
      running = '0;
      errors  = 0;
      foreach (present[i]) begin
        present[i]   = 1'b0;
        total_len[i] = '0;
      end
    endfunction

    function void store_step(index_item_t it);
      logic [POS_W:0] sum;
      if (it.path >= MAX_PATHS || cursor >= MAX_STEPS)
        return;
      // A fresh range starts both on request and on the first append to a path.
      if (it.opens || !present[it.path]) begin
        running            = '0;
        range_lo[it.path]  = cursor;
        present[it.path]   = 1'b1;
      end
      first_word[cursor]  = it.hi;
      second_word[cursor] = it.lo;
      start_pos[cursor]   = running;
      cursor              = cursor + 1;
      range_end[it.path]  = cursor;
      sum = {1'b0, running} + {{(POS_W + 1 - LEN_W){1'b0}}, it.len};
      running = (sum > {1'b0, POS_MAX}) ? POS_MAX : sum[POS_W-1:0];
      total_len[it.path] = running;
    endfunction

    function lookup_result_t predict_lookup(index_item_t it);
      lookup_result_t r;
      int unsigned    lo;
      int unsigned    hi;
      int unsigned    mid;
      r      = '0;
      r.past = 1'b1;
      if (it.path >= MAX_PATHS || !present[it.path]) begin
        r.unknown = 1'b1;
        return r;
      end
      r.total = total_len[it.path];
      lo = range_lo[it.path];
      hi = range_end[it.path];
      if (hi > MAX_STEPS)
        hi = MAX_STEPS;
      if (lo >= hi || it.pos >= r.total)
        return r;
      // The bisection runs over the slots as stored, even where another path's
      // steps sit inside this range and the start positions are not sorted.
      while (hi > lo + 1) begin
        mid = lo + (hi - lo) / 2;
        if (it.pos < start_pos[mid])
          hi = mid;
        else
          lo = mid;
      end
      r.hi   = first_word[lo];
      r.lo   = second_word[lo];
      r.past = 1'b0;
      return r;
    endfunction

    function void absorb_item(index_item_t it);
      if (it.op == OP_APPEND)
        store_step(it);
      else
        awaited_lookups = {awaited_lookups, predict_lookup(it)};
    endfunction

    function void compare_lookup(lookup_result_t got);
      lookup_result_t want;
      if (awaited_lookups.size() == 0) begin
        $error("unexpected result beat: hi %h lo %h length %h", got.hi, got.lo, got.total);
        errors++;
        return;
      end
      want = awaited_lookups.pop_front();
      if (got.hi !== want.hi) begin
        $error("found_step_hi: expected %h, got %h", want.hi, got.hi);
        errors++;
      end
      if (got.lo !== want.lo) begin
        $error("found_step_lo: expected %h, got %h", want.lo, got.lo);
        errors++;
      end
      if (got.total !== want.total) begin
        $error("path_length: expected %h, got %h", want.total, got.total);
        errors++;
      end
      if (got.past !== want.past) begin
        $error("past_end: expected %b, got %b", want.past, got.past);
        errors++;
      end
      if (got.unknown !== want.unknown) begin
        $error("unknown_path: expected %b, got %b", want.unknown, got.unknown);
        errors++;
      end
    endfunction

    function int pending();
      return awaited_lookups.size();
    endfunction
  endclass

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  logic [IN_DATA_W-1:0]  s_tdata = '0;
  logic [USER_W-1:0]     s_tuser = '0;
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_tdata;
  logic [USER_W-1:0]     m_tuser;

  position_lookup_board board;

  int          send_idle_pct = 0;
  int          recv_idle_pct = 0;
  logic        hold_req = 1'b0;
  logic        hold_taken = 1'b0;
  int          hold_left = 0;
  int          quiet_cycles = 0;
  int unsigned last_path = 1;

  path_position_index_unit dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  function automatic logic [WORD_W-1:0] rand_word();
    return {$urandom, $urandom};
  endfunction

  function automatic logic [POS_W-1:0] rand_position();
    logic [63:0] w;
    w = {$urandom, $urandom};
    return w[POS_W-1:0];
  endfunction

  // Mostly short nodes so that positions stay easy to hit, with the extremes
  // and the full 32-bit range mixed in.
  function automatic logic [LEN_W-1:0] pick_length();
    int r;
    r = $urandom_range(99);
    if (r < 45)
      return LEN_W'($urandom_range(1000));
    else if (r < 55)
      return '0;
    else if (r < 62)
      return '1;
    else if (r < 80)
      return LEN_W'($urandom_range(65535));
    else
      return $urandom;
  endfunction

  // Most positions land inside the path; the rest probe its edges and beyond.
  function automatic logic [POS_W-1:0] pick_position(input logic [POS_W-1:0] total);
    int r;
    r = $urandom_range(99);
    if (r < 60 && total != '0)
      return rand_position() % total;
    else if (r < 68)
      return total;
    else if (r < 76)
      return total - 1'b1;
    else if (r < 82)
      return '0;
    else
      return rand_position();
  endfunction

  // The fields that an operation does not use carry random noise.
  function automatic index_item_t make_append(input logic [PATH_ID_W-1:0] path,
                                              input logic opens,
                                              input logic [WORD_W-1:0] hi,
                                              input logic [WORD_W-1:0] lo,
                                              input logic [LEN_W-1:0] len);
    index_item_t it;
    it.op    = OP_APPEND;
    it.path  = path;
    it.opens = opens;
    it.hi    = hi;
    it.lo    = lo;
    it.len   = len;
    it.pos   = rand_position();
    return it;
  endfunction

  function automatic index_item_t make_query(input logic [PATH_ID_W-1:0] path,
                                             input logic [POS_W-1:0] pos);
    index_item_t it;
    it.op    = OP_QUERY;
    it.path  = path;
    it.opens = 1'($urandom_range(1));
    it.hi    = rand_word();
    it.lo    = rand_word();
    it.len   = $urandom;
    it.pos   = pos;
    return it;
  endfunction

  // Offers one beat, possibly after an idle gap, and hands it to the board at
  // the edge where it is taken, so the board is current when the next beat is
  // chosen.
  task automatic send_item(input index_item_t it);
    logic [IN_DATA_W-1:0] data;
    logic [USER_W-1:0]    user;
    while ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    data = '0;
    data[IN_PATH_LSB +: PATH_ID_W] = it.path;
    data[IN_HI_LSB +: WORD_W]      = it.hi;
    data[IN_LO_LSB +: WORD_W]      = it.lo;
    data[IN_LEN_LSB +: LEN_W]      = it.len;
    data[IN_POS_LSB +: POS_W]      = it.pos;
    user = '0;
    user[IN_USER_OP]    = it.op;
    user[IN_USER_FIRST] = it.opens;
    s_tvalid <= 1'b1;
    s_tdata  <= data;
    s_tuser  <= user;
    do
      @(posedge clk);
    while (!s_tready);
    board.absorb_item(it);
  endtask

  // Appends mostly continue the path last written, which builds long ranges;
  // the others interleave paths or reopen them. Path 0 is left alone here so
  // that its interleaved range from the opening checks stays in place for the
  // closing queries.
  task automatic random_items(input int count);
    int unsigned path;
    int          n;
    for (n = 0; n < count; n++) begin
      if ($urandom_range(99) < 55) begin
        if ($urandom_range(99) < 60)
          path = last_path;
        else if ($urandom_range(19) == 0)
          path = 255;
        else
          path = $urandom_range(31, 1);
        send_item(make_append(PATH_ID_W'(path), 1'($urandom_range(99) < 15), rand_word(),
                              rand_word(), pick_length()));
        last_path = path;
      end else begin
        if ($urandom_range(99) < 80)
          path = ($urandom_range(19) == 0) ? 255 : $urandom_range(31);
        else
          path = $urandom_range(255);
        send_item(make_query(PATH_ID_W'(path), pick_position(board.total_len[path])));
      end
    end
  endtask

  // The receiver: random refusals at the current rate, and once a long hold-off
  // while the sender keeps offering, so the unit backs up and refuses input.
  always @(posedge clk) begin
    if (hold_left != 0) begin
      m_tready  <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (hold_req && !hold_taken) begin
      hold_taken <= 1'b1;
      hold_left  <= HOLD_CYCLES;
      m_tready   <= 1'b0;
    end else begin
      m_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Result beats are compared as they are taken.
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready)
      board.compare_lookup('{hi: m_tdata[OUT_HI_LSB +: WORD_W],
                             lo: m_tdata[OUT_LO_LSB +: WORD_W],
                             total: m_tdata[OUT_LEN_LSB +: POS_W],
                             past: m_tuser[OUT_USER_PAST],
                             unknown: m_tuser[OUT_USER_UNKNWN]});
  end

  // Hang detection: any accepted beat on either side restarts the count.
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == STALL_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    board = new();
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // The sender idles less than the receiver to begin with.
    send_idle_pct = 28;
    recv_idle_pct <= 65;

    // Queries before anything is stored report unknown paths.
    send_item(make_query(8'd0, '0));
    send_item(make_query(8'd255, POS_MAX));
    // Path 0 opens at slot 0 with a zero-length node, so its length is still zero.
    send_item(make_append(8'd0, 1'b1, '1, '1, '0));
    send_item(make_query(8'd0, '0));
    send_item(make_append(8'd0, 1'b0, 64'h8000_0000_0000_0000, 64'h7fff_ffff_ffff_ffff, '1));
    send_item(make_append(8'd0, 1'b0, '0, '0, 32'd1));
    // Probes around the boundary between the widest node and the last one.
    send_item(make_query(8'd0, '0));
    send_item(make_query(8'd0, 48'h0000_ffff_fffe));
    send_item(make_query(8'd0, 48'h0000_ffff_ffff));
    send_item(make_query(8'd0, 48'h0001_0000_0000));
    // An append without the open flag to an absent path still opens it.
    send_item(make_append(8'd255, 1'b0, rand_word(), rand_word(), 32'd5));
    // Interleaved append: path 0 carries on from path 255's running position.
    send_item(make_append(8'd0, 1'b0, rand_word(), rand_word(), 32'd3));
    send_item(make_query(8'd0, 48'd7));
    send_item(make_query(8'd0, 48'd4));
    // Reopening a present path drops its old range.
    send_item(make_append(8'd255, 1'b1, rand_word(), rand_word(), 32'd7));
    send_item(make_query(8'd255, '0));
    send_item(make_query(8'd255, 48'd6));
    send_item(make_query(8'd255, 48'd7));
    send_item(make_query(8'd255, POS_MAX));
    send_item(make_query(8'd128, rand_position()));

    random_items(380);

    // Now the receiver is the quicker side.
    send_idle_pct = 65;
    recv_idle_pct <= 28;
    random_items(380);

    // Full speed on both sides, starting with the long receiver hold-off.
    send_idle_pct = 0;
    recv_idle_pct <= 0;
    hold_req <= 1'b1;
    random_items(380);

    // A closing mix of queries on the interleaved path 0 and appends to any
    // path, path 0 included.
    repeat (60) begin
      if ($urandom_range(1) == 0)
        send_item(make_query(8'd0, pick_position(board.total_len[0])));
      else
        send_item(make_append(PATH_ID_W'($urandom_range(255)), 1'($urandom_range(1)),
                              rand_word(), rand_word(), pick_length()));
    end
    s_tvalid <= 1'b0;

    while (board.pending() != 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (board.errors == 0 && board.pending() == 0)
      $display("SCOREBOARD CLEAN");
    else
      $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

>>> sim.f
+incdir+sv
sv/ppi_pkg.sv
sv/ppi_ctrl.sv
sv/ppi_dp.sv
sv/path_position_index_unit.sv
sv/ppi_checker.sv
test/path_position_index_unit_test.sv
